// ===== rtl/pidema_pkg.sv =====
// Package for the PID controller with filtered derivative.
// Widths, configuration indexes, controller states and datapath commands.
// No dependencies.
package pidema_pkg;

	// item fields and configuration
	localparam int VAL_W      = 16;
	localparam int DT_W       = 16;
	localparam int DRIVE_W    = 32;
	localparam int GAIN_W     = 32;
	localparam int FRAC_W     = 17;
	localparam int LIM_W      = 23;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// internal state and work widths
	localparam int ERR_W  = 17;   // target - measurement
	localparam int DERR_W = 18;   // previous error - error
	localparam int ES_W   = 24;   // integral
	localparam int DER_W  = 26;   // smoothed derivative, Q.8
	localparam int MA_W   = 34;
	localparam int MB_W   = 29;
	localparam int PROD_W = MA_W + MB_W;
	localparam int XI_W   = 56;   // gain_i * integral
	localparam int ILO_W  = 28;   // low split of XI for the dt multiply
	localparam int XD_W   = 50;   // gain_d * D / 256
	localparam int ACC_W  = 72;
	localparam int SUM_W  = 64;
	localparam int DIFF_W = DRIVE_W + 1;

	localparam int FRAC_SH = 16;
	localparam int DER_SH  = 8;

	// divider: 72-bit dividend, 16-bit divisor, 8 quotient bits per cycle
	localparam int DIV_W    = ACC_W;
	localparam int DIV_R_W  = DT_W + 1;
	localparam int DIV_STEP = 8;
	localparam int DIV_ITER = DIV_W / DIV_STEP;
	localparam int CNT_W    = $clog2(DIV_ITER + 1);

	localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);
	localparam logic [DT_W-1:0]   MS_PER_S = DT_W'(1000);

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_SMOOTH  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_FILT_WEIGHT = CFG_IDX_W'(5);

	localparam logic [LIM_W-1:0]  LIM_RST = LIM_W'(1000);
	localparam logic [FRAC_W-1:0] W_RST   = FRAC_W'(32768);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SET, ST_ERR, ST_INTEG, ST_MUL_WD, ST_MUL_WDN, ST_DACC, ST_DSET,
		ST_MUL_P, ST_MUL_I, ST_XI, ST_MUL_IL, ST_MUL_IH, ST_IACC, ST_DIV_I, ST_WAIT_I,
		ST_ADD_I, ST_MUL_D, ST_XD, ST_XD1000, ST_DIV_D, ST_WAIT_D, ST_ADD_D, ST_UTR,
		ST_USAT, ST_DIFF, ST_MUL_TF, ST_FB, ST_FTR, ST_FIN
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_SET, OP_ERR, OP_INTEG, OP_MUL_WD, OP_MUL_WDN, OP_DACC, OP_DSET,
		OP_MUL_P, OP_MUL_I, OP_XI, OP_MUL_IL, OP_MUL_IH, OP_IACC, OP_DIV_I,
		OP_ADD_I, OP_MUL_D, OP_XD, OP_XD1000, OP_DIV_D, OP_ADD_D, OP_UTR,
		OP_USAT, OP_DIFF, OP_MUL_TF, OP_FB, OP_FTR, OP_FIN
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

endpackage

// ===== rtl/pid_controller_ema_derivative.sv =====
// Top level of the PID controller with EMA-filtered derivative.
// Joins the controller and the datapath. Depends on pidema_pkg, pidema_ctrl, pidema_dp.
//
//  port group   handshake            payload
//  input        in_valid / in_ready  command, value, elapsed_ms
//  output       out_valid/out_ready  drive
//  config       cfg_we               cfg_index, cfg_data
//
// A set-target item passes through the SET state before drive is valid; a control step
// runs from ERR to FIN, with the two 72-bit divisions on the shared divider (start,
// iterations of 8 quotient bits, sign fix and done) and the rest as steps around one
// 34x29 multiplier. Input is taken again the cycle after the result is issued;
// a stalled output holds the next result back.
// Reset is asynchronous, active low; it restores register defaults and clears state.
module pid_controller_ema_derivative (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic                                     command,
	input  logic signed [pidema_pkg::VAL_W-1:0]      value,
	input  logic        [pidema_pkg::DT_W-1:0]       elapsed_ms,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic signed [pidema_pkg::DRIVE_W-1:0]    drive,
	input  logic                                     cfg_we,
	input  logic        [pidema_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [pidema_pkg::CFG_DATA_W-1:0] cfg_data
);

	pidema_pkg::dp_cmd_t  dp_cmd;
	pidema_pkg::dp_stat_t dp_stat;

	pidema_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.stat      (dp_stat)
	);

	pidema_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.value      (value),
		.elapsed_ms (elapsed_ms),
		.cmd        (dp_cmd),
		.stat       (dp_stat),
		.drive      (drive)
	);

endmodule

// ===== rtl/pidema_div.sv =====
// Iterative signed divider, 72-bit dividend by 16-bit positive divisor.
// Restoring, 8 quotient bits per cycle, truncates toward zero.
// Depends on pidema_pkg.
module pidema_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [pidema_pkg::DIV_W-1:0]    dividend,
	input  logic        [pidema_pkg::DT_W-1:0]     divisor,
	output logic signed [pidema_pkg::DIV_W-1:0]    quot,
	output logic                                   done
);

	logic                                busy_q;
	logic                                fix_q;
	logic                                done_q;
	logic [pidema_pkg::CNT_W-1:0]        cnt_q;
	logic                                neg_q;
	logic [pidema_pkg::DIV_W-1:0]        quo_q;
	logic [pidema_pkg::DIV_R_W-1:0]      rem_q;
	logic [pidema_pkg::DT_W-1:0]         dvs_q;
	logic [pidema_pkg::DIV_W-1:0]        q_n;
	logic [pidema_pkg::DIV_R_W-1:0]      r_n;

	always_comb begin
		r_n = rem_q;
		q_n = quo_q;
		for (int k = 0; k < pidema_pkg::DIV_STEP; k++) begin
			r_n = {r_n[pidema_pkg::DIV_R_W-2:0], q_n[pidema_pkg::DIV_W-1]};
			q_n = {q_n[pidema_pkg::DIV_W-2:0], 1'b0};
			if (r_n >= {1'b0, dvs_q}) begin
				r_n    = r_n - {1'b0, dvs_q};
				q_n[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pidema_pkg::CNT_W'(pidema_pkg::DIV_ITER);
			end else if (busy_q) begin
				cnt_q <= cnt_q - pidema_pkg::CNT_W'(1);
				if (cnt_q == pidema_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					fix_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[pidema_pkg::DIV_W-1];
			quo_q <= dividend[pidema_pkg::DIV_W-1] ? pidema_pkg::DIV_W'(-dividend)
			                                        : pidema_pkg::DIV_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= q_n;
			rem_q <= r_n;
		end else if (fix_q) begin
			quo_q <= neg_q ? -quo_q : quo_q;
		end
	end

	assign quot = signed'(quo_q);
	assign done = done_q;

endmodule

// ===== rtl/pidema_dp.sv =====
// Datapath: configuration registers, controller state, shared multiplier,
// accumulator and the divider. Executes one command per cycle.
// Depends on pidema_pkg and pidema_div.
module pidema_dp (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic        [pidema_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [pidema_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic signed [pidema_pkg::VAL_W-1:0]      value,
	input  logic        [pidema_pkg::DT_W-1:0]       elapsed_ms,
	input  pidema_pkg::dp_cmd_t                      cmd,
	output pidema_pkg::dp_stat_t                     stat,
	output logic signed [pidema_pkg::DRIVE_W-1:0]    drive
);

	localparam int ACC_W = pidema_pkg::ACC_W;

	function automatic logic [pidema_pkg::FRAC_W-1:0] frac_clamp(
		input logic [pidema_pkg::FRAC_W-1:0] v);
		return (v > pidema_pkg::FRAC_ONE) ? pidema_pkg::FRAC_ONE : v;
	endfunction

	// arithmetic shift right, rounded toward zero
	function automatic logic signed [ACC_W-1:0] trunc_shift(
		input logic signed [ACC_W-1:0] x, input int unsigned sh);
		logic [ACC_W-1:0]        mask;
		logic signed [ACC_W-1:0] q;
		mask = ~({ACC_W{1'b1}} << sh);
		q    = x >>> sh;
		if (x[ACC_W-1] && ((x & mask) != '0))
			q = q + ACC_W'(1);
		return q;
	endfunction

	function automatic logic signed [pidema_pkg::DRIVE_W-1:0] sat32(
		input logic signed [ACC_W-1:0] x);
		if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff}))
			return 32'sh7fff_ffff;
		if (x < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000}))
			return 32'sh8000_0000;
		return pidema_pkg::DRIVE_W'(x);
	endfunction

	// configuration
	logic signed [pidema_pkg::GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic        [pidema_pkg::FRAC_W-1:0]  tf_q, w_q;
	logic        [pidema_pkg::LIM_W-1:0]   lim_q;

	// controller state
	logic signed [pidema_pkg::VAL_W-1:0]   target_q;
	logic signed [pidema_pkg::ES_W-1:0]    es_q;
	logic signed [pidema_pkg::ERR_W-1:0]   prev_e_q;
	logic signed [pidema_pkg::DER_W-1:0]   der_q;
	logic signed [pidema_pkg::DRIVE_W-1:0] prev_drive_q;

	// item and work registers
	logic signed [pidema_pkg::VAL_W-1:0]   val_q;
	logic        [pidema_pkg::DT_W-1:0]    dt_q;
	logic signed [pidema_pkg::ERR_W-1:0]   e_q;
	logic signed [pidema_pkg::DERR_W-1:0]  d_q;
	logic signed [pidema_pkg::PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]               acc_q;
	logic signed [pidema_pkg::XI_W-1:0]    xi_q;
	logic signed [pidema_pkg::XD_W-1:0]    xd_q;
	logic signed [pidema_pkg::SUM_W-1:0]   sum_q;
	logic signed [pidema_pkg::DRIVE_W-1:0] u_q;
	logic signed [pidema_pkg::DIFF_W-1:0]  diff_q;
	logic signed [pidema_pkg::DRIVE_W-1:0] drive_q;

	logic signed [pidema_pkg::MA_W-1:0]    mul_a;
	logic signed [pidema_pkg::MB_W-1:0]    mul_b;
	logic signed [pidema_pkg::ES_W:0]      es_sum;
	logic signed [pidema_pkg::ES_W:0]      lim_s;
	logic signed [pidema_pkg::ES_W:0]      es_sat;
	logic signed [ACC_W-1:0]               prod_x;
	logic signed [ACC_W-1:0]               xd_x;
	logic signed [ACC_W-1:0]               drive_trunc;
	logic signed [pidema_pkg::DRIVE_W-1:0] drive_sat;
	logic                                  div_start;
	logic        [pidema_pkg::DT_W-1:0]    div_dvs;
	logic signed [pidema_pkg::DIV_W-1:0]   div_quot;
	logic                                  div_done;

	pidema_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (div_dvs),
		.quot     (div_quot),
		.done     (div_done)
	);

	assign div_start = (cmd.op == pidema_pkg::OP_DIV_I) || (cmd.op == pidema_pkg::OP_DIV_D);
	assign div_dvs   = (cmd.op == pidema_pkg::OP_DIV_I) ? pidema_pkg::MS_PER_S : dt_q;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pidema_pkg::OP_MUL_WD: begin
				mul_a = pidema_pkg::MA_W'(der_q);
				mul_b = signed'(pidema_pkg::MB_W'(w_q));
			end
			pidema_pkg::OP_MUL_WDN: begin
				mul_a = pidema_pkg::MA_W'(d_q);
				mul_b = signed'(pidema_pkg::MB_W'(pidema_pkg::FRAC_ONE - w_q));
			end
			pidema_pkg::OP_MUL_P: begin
				mul_a = pidema_pkg::MA_W'(gain_p_q);
				mul_b = pidema_pkg::MB_W'(e_q);
			end
			pidema_pkg::OP_MUL_I: begin
				mul_a = pidema_pkg::MA_W'(gain_i_q);
				mul_b = pidema_pkg::MB_W'(es_q);
			end
			pidema_pkg::OP_MUL_IL: begin
				mul_a = signed'(pidema_pkg::MA_W'(dt_q));
				mul_b = signed'(pidema_pkg::MB_W'(xi_q[pidema_pkg::ILO_W-1:0]));
			end
			pidema_pkg::OP_MUL_IH: begin
				mul_a = signed'(pidema_pkg::MA_W'(dt_q));
				mul_b = pidema_pkg::MB_W'(signed'(xi_q[pidema_pkg::XI_W-1:pidema_pkg::ILO_W]));
			end
			pidema_pkg::OP_MUL_D: begin
				mul_a = pidema_pkg::MA_W'(gain_d_q);
				mul_b = pidema_pkg::MB_W'(der_q);
			end
			pidema_pkg::OP_MUL_TF: begin
				mul_a = pidema_pkg::MA_W'(diff_q);
				mul_b = signed'(pidema_pkg::MB_W'(tf_q));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign es_sum = (pidema_pkg::ES_W+1)'(es_q) + (pidema_pkg::ES_W+1)'(e_q);
	assign lim_s  = signed'((pidema_pkg::ES_W+1)'(lim_q));
	assign es_sat = (es_sum > lim_s) ? lim_s : ((es_sum < -lim_s) ? -lim_s : es_sum);

	assign prod_x      = ACC_W'(prod_q);
	assign xd_x        = ACC_W'(xd_q);
	assign drive_trunc = acc_q;
	assign drive_sat   = sat32(drive_trunc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			tf_q         <= '0;
			lim_q        <= pidema_pkg::LIM_RST;
			w_q          <= pidema_pkg::W_RST;
			target_q     <= '0;
			es_q         <= '0;
			prev_e_q     <= '0;
			der_q        <= '0;
			prev_drive_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pidema_pkg::CFG_GAIN_P:      gain_p_q <= signed'(cfg_data);
					pidema_pkg::CFG_GAIN_I:      gain_i_q <= signed'(cfg_data);
					pidema_pkg::CFG_GAIN_D:      gain_d_q <= signed'(cfg_data);
					pidema_pkg::CFG_OUT_SMOOTH:
						tf_q <= frac_clamp(cfg_data[pidema_pkg::FRAC_W-1:0]);
					pidema_pkg::CFG_INT_LIMIT:   lim_q <= cfg_data[pidema_pkg::LIM_W-1:0];
					pidema_pkg::CFG_FILT_WEIGHT:
						w_q <= frac_clamp(cfg_data[pidema_pkg::FRAC_W-1:0]);
					default: ;
				endcase
			end
			case (cmd.op)
				pidema_pkg::OP_SET: begin
					target_q     <= val_q;
					es_q         <= '0;
					prev_e_q     <= '0;
					der_q        <= '0;
					prev_drive_q <= '0;
				end
				pidema_pkg::OP_INTEG: begin
					es_q     <= pidema_pkg::ES_W'(es_sat);
					prev_e_q <= e_q;
				end
				pidema_pkg::OP_DSET: der_q <= pidema_pkg::DER_W'(trunc_shift(acc_q,
					pidema_pkg::FRAC_SH));
				pidema_pkg::OP_FIN:  prev_drive_q <= drive_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			val_q <= value;
			dt_q  <= (elapsed_ms == '0) ? pidema_pkg::DT_W'(1) : elapsed_ms;
		end
		case (cmd.op)
			pidema_pkg::OP_SET:    drive_q <= pidema_pkg::DRIVE_W'(val_q);
			pidema_pkg::OP_ERR:
				e_q <= pidema_pkg::ERR_W'(target_q) - pidema_pkg::ERR_W'(val_q);
			pidema_pkg::OP_INTEG:
				d_q <= pidema_pkg::DERR_W'(prev_e_q) - pidema_pkg::DERR_W'(e_q);
			pidema_pkg::OP_MUL_WDN: acc_q <= prod_x;
			pidema_pkg::OP_DACC:   acc_q <= acc_q + (prod_x <<< pidema_pkg::DER_SH);
			pidema_pkg::OP_MUL_I:  sum_q <= pidema_pkg::SUM_W'(prod_q);
			pidema_pkg::OP_XI:     xi_q <= pidema_pkg::XI_W'(prod_q);
			pidema_pkg::OP_MUL_IH: acc_q <= prod_x;
			pidema_pkg::OP_IACC:   acc_q <= acc_q + (prod_x <<< pidema_pkg::ILO_W);
			pidema_pkg::OP_ADD_I,
			pidema_pkg::OP_ADD_D:
				sum_q <= sum_q + pidema_pkg::SUM_W'(div_quot);
			pidema_pkg::OP_XD:
				xd_q <= pidema_pkg::XD_W'(trunc_shift(prod_x, pidema_pkg::DER_SH));
			// x * 1000 = x * 1024 - x * 16 - x * 8
			pidema_pkg::OP_XD1000: acc_q <= (xd_x <<< 10) - (xd_x <<< 4) - (xd_x <<< 3);
			pidema_pkg::OP_UTR:
				sum_q <= pidema_pkg::SUM_W'(trunc_shift(ACC_W'(sum_q), pidema_pkg::FRAC_SH));
			pidema_pkg::OP_USAT:   u_q <= sat32(ACC_W'(sum_q));
			pidema_pkg::OP_DIFF:
				diff_q <= pidema_pkg::DIFF_W'(u_q) - pidema_pkg::DIFF_W'(prev_drive_q);
			pidema_pkg::OP_FB:     acc_q <= (ACC_W'(u_q) <<< pidema_pkg::FRAC_SH) - prod_x;
			pidema_pkg::OP_FTR:    acc_q <= trunc_shift(acc_q, pidema_pkg::FRAC_SH);
			pidema_pkg::OP_FIN:    drive_q <= drive_sat;
			default: ;
		endcase
	end

	assign stat.div_done = div_done;
	assign drive         = drive_q;

endmodule

// ===== rtl/pidema_ctrl.sv =====
// Controller: sequences one item through the datapath, one command a cycle except
// while it waits on the divider or on a stalled output, and owns the input ready and the output valid.
// Depends on pidema_pkg.
module pidema_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	output logic                  out_valid,
	input  logic                  out_ready,
	output pidema_pkg::dp_cmd_t   cmd,
	input  pidema_pkg::dp_stat_t  stat
);

	pidema_pkg::state_t state_q, state_n;
	logic               out_valid_q;
	logic               slot_free;
	logic               issue_out;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_n = state_q;
		case (state_q)
			pidema_pkg::ST_IDLE:
				if (in_valid)
					state_n = command ? pidema_pkg::ST_ERR : pidema_pkg::ST_SET;
			pidema_pkg::ST_SET:     if (slot_free) state_n = pidema_pkg::ST_IDLE;
			pidema_pkg::ST_ERR:     state_n = pidema_pkg::ST_INTEG;
			pidema_pkg::ST_INTEG:   state_n = pidema_pkg::ST_MUL_WD;
			pidema_pkg::ST_MUL_WD:  state_n = pidema_pkg::ST_MUL_WDN;
			pidema_pkg::ST_MUL_WDN: state_n = pidema_pkg::ST_DACC;
			pidema_pkg::ST_DACC:    state_n = pidema_pkg::ST_DSET;
			pidema_pkg::ST_DSET:    state_n = pidema_pkg::ST_MUL_P;
			pidema_pkg::ST_MUL_P:   state_n = pidema_pkg::ST_MUL_I;
			pidema_pkg::ST_MUL_I:   state_n = pidema_pkg::ST_XI;
			pidema_pkg::ST_XI:      state_n = pidema_pkg::ST_MUL_IL;
			pidema_pkg::ST_MUL_IL:  state_n = pidema_pkg::ST_MUL_IH;
			pidema_pkg::ST_MUL_IH:  state_n = pidema_pkg::ST_IACC;
			pidema_pkg::ST_IACC:    state_n = pidema_pkg::ST_DIV_I;
			pidema_pkg::ST_DIV_I:   state_n = pidema_pkg::ST_WAIT_I;
			pidema_pkg::ST_WAIT_I:  if (stat.div_done) state_n = pidema_pkg::ST_ADD_I;
			pidema_pkg::ST_ADD_I:   state_n = pidema_pkg::ST_MUL_D;
			pidema_pkg::ST_MUL_D:   state_n = pidema_pkg::ST_XD;
			pidema_pkg::ST_XD:      state_n = pidema_pkg::ST_XD1000;
			pidema_pkg::ST_XD1000:  state_n = pidema_pkg::ST_DIV_D;
			pidema_pkg::ST_DIV_D:   state_n = pidema_pkg::ST_WAIT_D;
			pidema_pkg::ST_WAIT_D:  if (stat.div_done) state_n = pidema_pkg::ST_ADD_D;
			pidema_pkg::ST_ADD_D:   state_n = pidema_pkg::ST_UTR;
			pidema_pkg::ST_UTR:     state_n = pidema_pkg::ST_USAT;
			pidema_pkg::ST_USAT:    state_n = pidema_pkg::ST_DIFF;
			pidema_pkg::ST_DIFF:    state_n = pidema_pkg::ST_MUL_TF;
			pidema_pkg::ST_MUL_TF:  state_n = pidema_pkg::ST_FB;
			pidema_pkg::ST_FB:      state_n = pidema_pkg::ST_FTR;
			pidema_pkg::ST_FTR:     state_n = pidema_pkg::ST_FIN;
			pidema_pkg::ST_FIN:     if (slot_free) state_n = pidema_pkg::ST_IDLE;
			default:                state_n = pidema_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		issue_out = 1'b0;
		cmd.load  = 1'b0;
		cmd.op    = pidema_pkg::OP_NONE;
		case (state_q)
			pidema_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			pidema_pkg::ST_SET: begin
				issue_out = slot_free;
				if (slot_free) cmd.op = pidema_pkg::OP_SET;
			end
			pidema_pkg::ST_ERR:     cmd.op = pidema_pkg::OP_ERR;
			pidema_pkg::ST_INTEG:   cmd.op = pidema_pkg::OP_INTEG;
			pidema_pkg::ST_MUL_WD:  cmd.op = pidema_pkg::OP_MUL_WD;
			pidema_pkg::ST_MUL_WDN: cmd.op = pidema_pkg::OP_MUL_WDN;
			pidema_pkg::ST_DACC:    cmd.op = pidema_pkg::OP_DACC;
			pidema_pkg::ST_DSET:    cmd.op = pidema_pkg::OP_DSET;
			pidema_pkg::ST_MUL_P:   cmd.op = pidema_pkg::OP_MUL_P;
			pidema_pkg::ST_MUL_I:   cmd.op = pidema_pkg::OP_MUL_I;
			pidema_pkg::ST_XI:      cmd.op = pidema_pkg::OP_XI;
			pidema_pkg::ST_MUL_IL:  cmd.op = pidema_pkg::OP_MUL_IL;
			pidema_pkg::ST_MUL_IH:  cmd.op = pidema_pkg::OP_MUL_IH;
			pidema_pkg::ST_IACC:    cmd.op = pidema_pkg::OP_IACC;
			pidema_pkg::ST_DIV_I:   cmd.op = pidema_pkg::OP_DIV_I;
			pidema_pkg::ST_WAIT_I:  cmd.op = pidema_pkg::OP_NONE;
			pidema_pkg::ST_ADD_I:   cmd.op = pidema_pkg::OP_ADD_I;
			pidema_pkg::ST_MUL_D:   cmd.op = pidema_pkg::OP_MUL_D;
			pidema_pkg::ST_XD:      cmd.op = pidema_pkg::OP_XD;
			pidema_pkg::ST_XD1000:  cmd.op = pidema_pkg::OP_XD1000;
			pidema_pkg::ST_DIV_D:   cmd.op = pidema_pkg::OP_DIV_D;
			pidema_pkg::ST_WAIT_D:  cmd.op = pidema_pkg::OP_NONE;
			pidema_pkg::ST_ADD_D:   cmd.op = pidema_pkg::OP_ADD_D;
			pidema_pkg::ST_UTR:     cmd.op = pidema_pkg::OP_UTR;
			pidema_pkg::ST_USAT:    cmd.op = pidema_pkg::OP_USAT;
			pidema_pkg::ST_DIFF:    cmd.op = pidema_pkg::OP_DIFF;
			pidema_pkg::ST_MUL_TF:  cmd.op = pidema_pkg::OP_MUL_TF;
			pidema_pkg::ST_FB:      cmd.op = pidema_pkg::OP_FB;
			pidema_pkg::ST_FTR:     cmd.op = pidema_pkg::OP_FTR;
			pidema_pkg::ST_FIN: begin
				issue_out = slot_free;
				if (slot_free) cmd.op = pidema_pkg::OP_FIN;
			end
			default:                cmd.op = pidema_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pidema_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (issue_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== tb/tb_pid_controller_ema_derivative.sv =====
// Self-checking testbench for pid_controller_ema_derivative: random and directed
// set-target and step items, drive values checked against an in-line PID predictor.
// Depends on pidema_pkg and the pid_controller_ema_derivative RTL.
`timescale 1ns / 100ps

module tb_pid_controller_ema_derivative;

	localparam logic   CMD_SET     = 1'b0;
	localparam logic   CMD_STEP    = 1'b1;
	localparam longint ONE_Q16     = 65536;
	localparam longint MS_PER_SEC  = 1000;
	localparam longint S32_MAX     = 64'sd2147483647;
	localparam longint S32_MIN     = -64'sd2147483648;
	localparam int     STALL_LIMIT = 2000;
	localparam int     PHASES      = 8;
	localparam int     PHASE_ITEMS = 200;

	typedef struct packed {
		logic        cmd;
		logic [15:0] val;
		logic [15:0] ms;
	} ctl_item_t;

	logic                                     clk        = 1'b0;
	logic                                     arst_n     = 1'b0;
	logic                                     in_valid   = 1'b0;
	logic                                     in_ready;
	logic                                     command    = CMD_SET;
	logic signed [pidema_pkg::VAL_W-1:0]      value      = '0;
	logic        [pidema_pkg::DT_W-1:0]       elapsed_ms = '0;
	logic                                     out_valid;
	logic                                     out_ready  = 1'b0;
	logic signed [pidema_pkg::DRIVE_W-1:0]    drive;
	logic                                     cfg_we     = 1'b0;
	logic        [pidema_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
	logic        [pidema_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

	ctl_item_t   pending_cmds[$];
	logic [31:0] drive_due[$];
	int          n_fail = 0;
	int          idle_cycles = 0;
	int          tx_wait = 0;
	int          rx_wait = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	// predictor registers and state
	longint kp = 0, ki = 0, kd = 0, tf = 0, ilim = 1000, wgt = 32768;
	longint tgt = 0, integ = 0, prev_err = 0, deriv = 0, prev_drive = 0;

	pid_controller_ema_derivative u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.value      (value),
		.elapsed_ms (elapsed_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.drive      (drive),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint sat32(input longint x);
		if (x > S32_MAX)
			return S32_MAX;
		if (x < S32_MIN)
			return S32_MIN;
		return x;
	endfunction

	function automatic longint frac_sat(input logic [16:0] x);
		return (longint'(x) > ONE_Q16) ? ONE_Q16 : longint'(x);
	endfunction

	function automatic logic [31:0] predict_drive(input logic cmd,
			input logic signed [15:0] v, input logic [15:0] ms);
		longint dt, e, d, x, q, r, p_t, i_t, d_t, u, drv;
		if (cmd == CMD_SET) begin
			tgt = longint'(v);
			integ = 0;
			prev_err = 0;
			deriv = 0;
			prev_drive = 0;
			return 32'(longint'(v));
		end
		dt = (ms == 0) ? 1 : longint'(ms);
		e = tgt - longint'(v);
		integ = integ + e;
		if (integ > ilim)
			integ = ilim;
		if (integ < -ilim)
			integ = -ilim;
		d = prev_err - e;
		deriv = (wgt * deriv + (ONE_Q16 - wgt) * (d * 256)) / ONE_Q16;
		p_t = kp * e;
		// integral term split so that x*dt cannot overflow
		x = ki * integ;
		q = x / MS_PER_SEC;
		r = x - q * MS_PER_SEC;
		i_t = q * dt + (r * dt) / MS_PER_SEC;
		x = (kd * deriv) / 256;
		d_t = (x * MS_PER_SEC) / dt;
		u = sat32((p_t + i_t + d_t) / ONE_Q16);
		drv = sat32((u * ONE_Q16 - tf * (u - prev_drive)) / ONE_Q16);
		prev_err = e;
		prev_drive = drv;
		return 32'(drv);
	endfunction

	task automatic write_reg(input logic [pidema_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			pidema_pkg::CFG_GAIN_P:      kp = longint'(signed'(data));
			pidema_pkg::CFG_GAIN_I:      ki = longint'(signed'(data));
			pidema_pkg::CFG_GAIN_D:      kd = longint'(signed'(data));
			pidema_pkg::CFG_OUT_SMOOTH:  tf = frac_sat(data[16:0]);
			pidema_pkg::CFG_INT_LIMIT:   ilim = longint'(data[22:0]);
			pidema_pkg::CFG_FILT_WEIGHT: wgt = frac_sat(data[16:0]);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [31:0] p, input logic [31:0] i,
			input logic [31:0] d, input logic [31:0] smooth, input logic [31:0] lim,
			input logic [31:0] w);
		write_reg(pidema_pkg::CFG_GAIN_P, p);
		write_reg(pidema_pkg::CFG_GAIN_I, i);
		write_reg(pidema_pkg::CFG_GAIN_D, d);
		write_reg(pidema_pkg::CFG_OUT_SMOOTH, smooth);
		write_reg(pidema_pkg::CFG_INT_LIMIT, lim);
		write_reg(pidema_pkg::CFG_FILT_WEIGHT, w);
		@(negedge clk);
	endtask

	task automatic queue_item(input logic cmd, input logic [15:0] v, input logic [15:0] ms);
		pending_cmds.push_back('{cmd: cmd, val: v, ms: ms});
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_cmds.size() != 0 || in_valid || drive_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_ms();
		case ($urandom_range(0, 19))
			0:       return 16'd0;
			1, 2:    return 16'($urandom);
			3, 4:    return 16'($urandom_range(900, 1100));
			default: return 16'($urandom_range(1, 50));
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return 32'd0;
			default: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_frac();
		case ($urandom_range(0, 4))
			0:       return {15'($urandom), 17'd0};
			1:       return {15'($urandom), 17'd65536};
			2:       return {15'($urandom), 17'($urandom)};   // may exceed one
			3:       return 32'd65535;
			default: return 32'($urandom_range(0, 65536));
		endcase
	endfunction

	// mostly set-target followed by a run of steps near the target, some noise
	task automatic gen_phase(input int n_items);
		int                 n;
		int                 run;
		logic signed [15:0] tv;
		logic        [15:0] meas;
		n = 0;
		while (n < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_item($urandom_range(0, 1) ? CMD_STEP : CMD_SET, 16'($urandom), pick_ms());
				n++;
			end else begin
				tv = 16'($urandom);
				queue_item(CMD_SET, tv, 16'($urandom));
				run = $urandom_range(3, 30);
				for (int k = 0; k < run; k++) begin
					if ($urandom_range(0, 7) == 0)
						meas = 16'($urandom);
					else
						meas = tv + 16'($urandom_range(0, 512)) - 16'd256;
					queue_item(CMD_STEP, meas, pick_ms());
				end
				n += run + 1;
			end
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		ctl_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_wait = 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				drive_due.push_back(predict_drive(command, value, elapsed_ms));
				if ($urandom_range(0, 31) == 0)
					tx_burst = !tx_burst;
				tx_wait = tx_burst ? 0 : $urandom_range(0, 5);
			end
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				nxt = pending_cmds.pop_front();
				in_valid <= 1'b1;
				command <= nxt.cmd;
				value <= nxt.val;
				elapsed_ms <= nxt.ms;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver and check
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (drive_due.size() == 0) begin
					$error("drive: no item expected, actual %0d", drive);
					n_fail++;
				end else begin
					want = drive_due.pop_front();
					if (drive !== want) begin
						$error("drive: expected %0d, actual %0d", $signed(want), drive);
						n_fail++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					rx_burst = !rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
			end else if (out_valid && rx_wait > 0) begin
				rx_wait--;
			end
			out_ready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles = 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: zero gains
		queue_item(CMD_SET, 16'd100, 16'd7);
		queue_item(CMD_STEP, 16'd50, 16'd10);
		wait_idle();

		load_config(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0000_8000,
			32'd1000, 32'h0000_4000);
		queue_item(CMD_SET, 16'h7FFF, 16'hFFFF);
		queue_item(CMD_STEP, 16'h8000, 16'd1);
		queue_item(CMD_STEP, 16'h7FFF, 16'hFFFF);
		queue_item(CMD_STEP, 16'd0, 16'd0);
		queue_item(CMD_SET, 16'h8000, 16'd0);
		queue_item(CMD_STEP, 16'h7FFF, 16'd1000);
		queue_item(CMD_STEP, 16'h8000, 16'd500);
		wait_idle();

		// max P and I gains, minimum D gain, oversized fractions, integral held at zero
		load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'hFF80_0000, 32'h0001_FFFF);
		queue_item(CMD_SET, 16'd0, 16'd1);
		queue_item(CMD_STEP, 16'h8000, 16'd0);
		queue_item(CMD_STEP, 16'h7FFF, 16'hFFFF);
		queue_item(CMD_STEP, 16'd1, 16'd1);
		queue_item(CMD_STEP, 16'hFFFF, 16'd2);
		wait_idle();

		load_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0,
			32'h007F_FFFF, 32'd0);
		queue_item(CMD_SET, 16'h7FFF, 16'd3);
		queue_item(CMD_STEP, 16'h8000, 16'd1);
		queue_item(CMD_STEP, 16'h8000, 16'd1);
		queue_item(CMD_STEP, 16'h8000, 16'd1);
		queue_item(CMD_STEP, 16'h7FFF, 16'hFFFF);
		queue_item(CMD_SET, 16'hFFFF, 16'd9);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65536,
					32'h007F_FFFF, 32'd65536);
				1: load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0,
					32'd0, 32'd0);
				default: load_config(pick_gain(), pick_gain(), pick_gain(), pick_frac(),
					$urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000), pick_frac());
			endcase
			gen_phase(PHASE_ITEMS);
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (n_fail == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
